// ===== rtl/mdrc_pkg.sv =====
// Shared types and constants for the motor duty ramp controller.
`timescale 1ns / 1ps

package mdrc_pkg;

    localparam int CFG_W      = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int DUTY_OUT_W = 8;
    localparam int S_DATA_W   = 8;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 16;

    typedef enum logic [1:0] {
        CMD_TICK      = 2'd0,
        CMD_ACTIVATE  = 2'd1,
        CMD_PREPARE   = 2'd2,
        CMD_DIRECTION = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACCEL_STEP = 2'd0,
        CFG_DECEL_STEP = 2'd1,
        CFG_CEILING    = 2'd2,
        CFG_PRESET_MIN = 2'd3
    } cfg_addr_t;

    typedef struct packed {
        logic                  we;
        cfg_addr_t             addr;
        logic [CFG_W-1:0]      wdata;
    } cfg_wr_t;

    // one input word after the input register
    typedef struct packed {
        cmd_t command;
        logic flag_value;
    } event_t;

    // one result word, fields from the top down
    typedef struct packed {
        logic                  is_decelerating;
        logic                  is_accelerating;
        logic                  is_stopped;
        logic                  direction_issued;
        logic                  accepted;
        logic                  stop_issued;
        logic [DUTY_OUT_W-1:0] duty_level;
        logic                  duty_written;
    } result_t;

endpackage

// ===== rtl/motor_duty_ramp_controller_top.sv =====
// Top level of the motor duty ramp controller.
//
//  channel | direction | word contents (low bit first)
//  s_      | in        | tuser: command[1:0]; tdata: flag_value[0], zeros above
//  m_      | out       | tdata: duty_written, duty_level[8:1], stop_issued,
//          |           |        accepted, direction_issued, is_stopped,
//          |           |        is_accelerating, is_decelerating, zeros above
//  cfg_    | in        | write enable, register index, 8-bit data
//
// One word per cycle sustained while the master accepts. The accept edge loads the input
// register; the edge that updates the state and loads the result register comes once the
// result register is empty or its word is leaving, and m_tvalid rises with that load.
// aresetn is synchronous; it restores the register defaults and a stopped motor.
// A stalled master holds the result register, which backs up into the input
// register and then s_tready.
`timescale 1ns / 1ps

module motor_duty_ramp_controller_top #(
    parameter int DUTY_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mdrc_pkg::S_DATA_W-1:0]   s_tdata,   // flag_value
    input  logic [mdrc_pkg::S_USER_W-1:0]   s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mdrc_pkg::M_DATA_W-1:0]   m_tdata,   // see table above
    input  logic                            cfg_we,
    input  logic [mdrc_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mdrc_pkg::CFG_W-1:0]      cfg_wdata
);
    import mdrc_pkg::*;

    event_t  s_event, ev;
    cfg_wr_t cfg;
    result_t res, m_res;
    logic    ev_valid, can_load, fire;

    assign s_event.command    = cmd_t'(s_tuser);
    assign s_event.flag_value = s_tdata[0];

    assign cfg.we    = cfg_we;
    assign cfg.addr  = cfg_addr_t'(cfg_addr);
    assign cfg.wdata = cfg_wdata;

    assign fire = ev_valid && can_load;

    mdrc_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_event  (s_event),
        .ev_valid (ev_valid),
        .ev       (ev),
        .ev_take  (fire)
    );

    mdrc_core #(
        .DUTY_BITS (DUTY_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .ev      (ev),
        .res     (res)
    );

    mdrc_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .res      (res),
        .can_load (can_load),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {{(M_DATA_W - $bits(result_t)){1'b0}}, m_res};

endmodule

// ===== rtl/mdrc_in_stage.sv =====
// Input register for event words.
`timescale 1ns / 1ps

module mdrc_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mdrc_pkg::event_t s_event,
    output logic            ev_valid,
    output mdrc_pkg::event_t ev,
    input  logic            ev_take
);
    import mdrc_pkg::*;

    logic   valid_reg, valid_next;
    event_t ev_reg;
    logic   load;

    assign s_ready    = !valid_reg || ev_take;
    assign load       = s_valid && s_ready;
    assign valid_next = load ? 1'b1 : (ev_take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            ev_reg <= s_event;
        end
    end

    assign ev_valid = valid_reg;
    assign ev       = ev_reg;

endmodule

// ===== rtl/mdrc_core.sv =====
// Ramp state, configuration registers and next-state logic for one event.
`timescale 1ns / 1ps

module mdrc_core #(
    parameter int DUTY_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  mdrc_pkg::cfg_wr_t cfg,
    input  logic              fire,
    input  mdrc_pkg::event_t  ev,
    output mdrc_pkg::result_t res
);
    import mdrc_pkg::*;

    localparam int W = ((DUTY_BITS > CFG_W) ? DUTY_BITS : CFG_W) + 1;
    localparam logic [DUTY_BITS-1:0] DUTY_MAX = '1;
    localparam logic [W-1:0] DUTY_MAX_W = {{(W-DUTY_BITS){1'b0}}, DUTY_MAX};
    localparam logic [W-1:0] FLOOR_W = W'(1);

    logic [CFG_W-1:0] accel_step_reg, decel_step_reg, ceiling_reg, preset_reg;

    logic [DUTY_BITS-1:0] duty_reg, duty_next;
    logic stopped_reg, stopped_next;
    logic active_reg, active_next;
    logic accel_reg, accel_next;
    logic decel_reg, decel_next;
    logic dir_reg, dir_next;

    logic [W-1:0] cur_w, sum_w, ceil_w, lim_w, acc_val, dec_val, pre_w, pre_clip, duty_ext;
    logic acc_ramp, dec_ramp;
    logic wrote, stop_now, acc_ok, dir_now;

    always_comb begin
        cur_w    = W'(duty_reg);
        sum_w    = cur_w + W'(accel_step_reg);
        ceil_w   = W'(ceiling_reg);
        acc_ramp = sum_w < ceil_w;
        acc_val  = acc_ramp ? sum_w : ceil_w;
        if (acc_val > DUTY_MAX_W) begin
            acc_val = DUTY_MAX_W;
        end
        // decrement keeps the ramp only while the result stays above the floor
        lim_w    = W'(decel_step_reg) + W'(2);
        dec_ramp = cur_w >= lim_w;
        dec_val  = dec_ramp ? (cur_w - W'(decel_step_reg)) : FLOOR_W;
        pre_w    = W'(preset_reg);
        pre_clip = (pre_w > DUTY_MAX_W) ? DUTY_MAX_W : pre_w;
    end

    always_comb begin
        duty_next    = duty_reg;
        stopped_next = stopped_reg;
        active_next  = active_reg;
        accel_next   = accel_reg;
        decel_next   = decel_reg;
        dir_next     = dir_reg;
        wrote        = 1'b0;
        stop_now     = 1'b0;
        acc_ok       = 1'b1;
        dir_now      = 1'b0;
        case (ev.command)
            CMD_TICK: begin
                if (!stopped_reg) begin
                    if (active_reg) begin
                        if (accel_reg) begin
                            duty_next = acc_val[DUTY_BITS-1:0];
                            wrote     = 1'b1;
                        end
                        accel_next = acc_ramp;
                    end else begin
                        if (decel_reg) begin
                            duty_next = dec_val[DUTY_BITS-1:0];
                            wrote     = 1'b1;
                        end
                        decel_next = dec_ramp;
                        if (!dec_ramp) begin
                            stopped_next = 1'b1;
                            stop_now     = 1'b1;
                            accel_next   = 1'b0;
                            decel_next   = 1'b0;
                        end
                    end
                end
            end
            CMD_ACTIVATE: begin
                active_next = ev.flag_value;
                if (ev.flag_value) begin
                    stopped_next = 1'b0;
                end
            end
            CMD_PREPARE: begin
                if (accel_reg || decel_reg) begin
                    acc_ok = 1'b0;
                end else begin
                    duty_next = pre_clip[DUTY_BITS-1:0];
                    wrote     = 1'b1;
                end
            end
            CMD_DIRECTION: begin
                if (stopped_reg) begin
                    dir_next = ev.flag_value;
                    dir_now  = 1'b1;
                end else begin
                    acc_ok = (dir_reg == ev.flag_value);
                end
            end
            default: begin
                acc_ok = 1'b1;
            end
        endcase
    end

    always_comb begin
        duty_ext             = W'(duty_next);
        res.duty_written     = wrote;
        res.duty_level       = duty_ext[DUTY_OUT_W-1:0];
        res.stop_issued      = stop_now;
        res.accepted         = acc_ok;
        res.direction_issued = dir_now;
        res.is_stopped       = stopped_next;
        res.is_accelerating  = accel_next;
        res.is_decelerating  = decel_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_step_reg <= CFG_W'(1);
            decel_step_reg <= CFG_W'(1);
            ceiling_reg    <= CFG_W'(255);
            preset_reg     <= CFG_W'(1);
            duty_reg       <= DUTY_BITS'(1);
            stopped_reg    <= 1'b1;
            active_reg     <= 1'b0;
            accel_reg      <= 1'b0;
            decel_reg      <= 1'b0;
            dir_reg        <= 1'b0;
        end else begin
            if (cfg.we) begin
                case (cfg.addr)
                    CFG_ACCEL_STEP: accel_step_reg <= cfg.wdata;
                    CFG_DECEL_STEP: decel_step_reg <= cfg.wdata;
                    CFG_CEILING:    ceiling_reg    <= cfg.wdata;
                    CFG_PRESET_MIN: preset_reg     <= cfg.wdata;
                    default:        ceiling_reg    <= ceiling_reg;
                endcase
            end
            if (fire) begin
                duty_reg    <= duty_next;
                stopped_reg <= stopped_next;
                active_reg  <= active_next;
                accel_reg   <= accel_next;
                decel_reg   <= decel_next;
                dir_reg     <= dir_next;
            end
        end
    end

endmodule

// ===== rtl/mdrc_out_stage.sv =====
// Result register on the master side.
`timescale 1ns / 1ps

module mdrc_out_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  mdrc_pkg::result_t  res,
    output logic               can_load,
    output logic               m_valid,
    input  logic               m_ready,
    output mdrc_pkg::result_t  m_res
);
    import mdrc_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign can_load   = !valid_reg || m_ready;
    assign valid_next = load ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

// ===== rtl/mdrc_checker.sv =====
// Port-level checker for the motor duty ramp controller, bound to the top.
`timescale 1ns / 1ps

module mdrc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mdrc_pkg::M_DATA_W-1:0] m_tdata
);
    import mdrc_pkg::*;

    result_t r;
    assign r = result_t'(m_tdata[$bits(result_t)-1:0]);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_stopped_no_ramp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.is_stopped |-> !r.is_accelerating && !r.is_decelerating)
        else $error("ramp flag set while stopped");

    a_stop_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.stop_issued |-> r.is_stopped && r.accepted)
        else $error("stop issued without stopped state");

    a_dir_stopped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && r.direction_issued |-> r.is_stopped && r.accepted && !r.duty_written)
        else $error("direction driven while running");

endmodule

bind motor_duty_ramp_controller_top mdrc_checker u_mdrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== test/tb_motor_duty_ramp_controller_top.sv =====
// Self-checking testbench for the motor duty ramp controller: queued stimulus, ramp predictor.
`timescale 1ns / 1ps

module tb_motor_duty_ramp_controller_top;

    import mdrc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;
    localparam int DUTY_TOP    = 255;
    localparam int DUTY_FLOOR  = 1;

    typedef struct {
        cmd_t cmd;
        logic fv;
    } ramp_event_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;        // flag_value, zeros above
    logic [S_USER_W-1:0]   s_tuser   = CMD_TICK;  // command
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;               // duty_written, duty_level, stop_issued,
                                                  // accepted, direction_issued, is_stopped,
                                                  // is_accelerating, is_decelerating
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_ACCEL_STEP;
    logic [CFG_W-1:0]      cfg_wdata = '0;

    ramp_event_t pending_events[$];
    result_t     expected_results[$];
    int          events_queued   = 0;
    int          sender_idle_pct = 0;
    int          stall_pct       = 0;
    int          fail_count      = 0;
    int          cycle_count     = 0;
    logic        rx_hold         = 1'b0;
    logic        rx_hold_go      = 1'b0;

    // predictor copy of registers and state
    logic [7:0] accel_step_q = 8'd1;
    logic [7:0] decel_step_q = 8'd1;
    logic [7:0] ceiling_q    = 8'd255;
    logic [7:0] preset_q     = 8'd1;
    int         duty_q       = 1;
    logic       stopped_q    = 1'b1;
    logic       active_q     = 1'b0;
    logic       accel_q      = 1'b0;
    logic       decel_q      = 1'b0;
    logic       dir_q        = 1'b0;

    motor_duty_ramp_controller_top #(
        .DUTY_BITS(8)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int clamp_duty(int v);
        if (v < 0) return 0;
        if (v > DUTY_TOP) return DUTY_TOP;
        return v;
    endfunction

    function automatic result_t predict_ramp_event(cmd_t cmd, logic fv);
        result_t r;
        int      cur;
        int      ceil_v;
        logic    ramp;
        r = '0;
        r.accepted = 1'b1;
        case (cmd)
            CMD_TICK: begin
                if (!stopped_q) begin
                    cur = duty_q;
                    if (active_q) begin
                        ceil_v = int'(ceiling_q);
                        if (cur + int'(accel_step_q) < ceil_v) begin
                            cur  = cur + int'(accel_step_q);
                            ramp = 1'b1;
                        end else begin
                            cur  = ceil_v;
                            ramp = 1'b0;
                        end
                        if (accel_q) begin
                            duty_q         = clamp_duty(cur);
                            r.duty_written = 1'b1;
                        end
                        accel_q = ramp;
                    end else begin
                        if (cur - int'(decel_step_q) > DUTY_FLOOR) begin
                            cur  = cur - int'(decel_step_q);
                            ramp = 1'b1;
                        end else begin
                            cur       = DUTY_FLOOR;
                            ramp      = 1'b0;
                            stopped_q = 1'b1;
                        end
                        if (decel_q) begin
                            duty_q         = clamp_duty(cur);
                            r.duty_written = 1'b1;
                        end
                        decel_q = ramp;
                        if (stopped_q) begin
                            r.stop_issued = 1'b1;
                            accel_q       = 1'b0;
                            decel_q       = 1'b0;
                        end
                    end
                end
            end
            CMD_ACTIVATE: begin
                active_q = fv;
                if (fv) stopped_q = 1'b0;
            end
            CMD_PREPARE: begin
                if (accel_q || decel_q) begin
                    r.accepted = 1'b0;
                end else begin
                    duty_q         = clamp_duty(int'(preset_q));
                    r.duty_written = 1'b1;
                end
            end
            default: begin
                if (stopped_q) begin
                    dir_q              = fv;
                    r.direction_issued = 1'b1;
                end else begin
                    r.accepted = (dir_q == fv);
                end
            end
        endcase
        r.duty_level      = duty_q[7:0];
        r.is_stopped      = stopped_q;
        r.is_accelerating = accel_q;
        r.is_decelerating = decel_q;
        return r;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // driver: predicts at each accepted word
    always @(posedge aclk) begin : drive_proc
        ramp_event_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_ramp_event(cmd_t'(s_tuser), s_tdata[0]));
            if (!s_tvalid || s_tready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    ev = pending_events.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= ev.cmd;
                    s_tdata  <= {{(S_DATA_W-1){1'b0}}, ev.fv};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin : check_proc
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_results.size() == 0) begin
                    $error("result word %h with nothing expected", m_tdata);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("duty_written", int'(want.duty_written),
                                int'(got.duty_written));
                    check_field("duty_level", int'(want.duty_level), int'(got.duty_level));
                    check_field("stop_issued", int'(want.stop_issued),
                                int'(got.stop_issued));
                    check_field("accepted", int'(want.accepted), int'(got.accepted));
                    check_field("direction_issued", int'(want.direction_issued),
                                int'(got.direction_issued));
                    check_field("is_stopped", int'(want.is_stopped), int'(got.is_stopped));
                    check_field("is_accelerating", int'(want.is_accelerating),
                                int'(got.is_accelerating));
                    check_field("is_decelerating", int'(want.is_decelerating),
                                int'(got.is_decelerating));
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off
    initial begin : rx_hold_proc
        wait (rx_hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin : watchdog_proc
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic push_event(cmd_t cmd, logic fv);
        ramp_event_t ev;
        ev.cmd = cmd;
        ev.fv  = fv;
        pending_events.push_back(ev);
        events_queued++;
    endtask

    task automatic write_reg(cfg_addr_t idx, logic [7:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ACCEL_STEP: accel_step_q = val;
            CFG_DECEL_STEP: decel_step_q = val;
            CFG_CEILING:    ceiling_q    = val;
            default:        preset_q     = val;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_events.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly full soft-start / soft-stop runs, some noise
    task automatic fill_random(int n);
        int start;
        int k;
        start = events_queued;
        while (events_queued - start < n) begin
            if ($urandom_range(9) < 7) begin
                if ($urandom_range(1)) push_event(CMD_DIRECTION, 1'($urandom_range(1)));
                push_event(CMD_PREPARE, 1'($urandom_range(1)));
                push_event(CMD_ACTIVATE, 1'b1);
                k = $urandom_range(1, 40);
                repeat (k) push_event(CMD_TICK, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0) push_event(CMD_DIRECTION, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0) push_event(CMD_PREPARE, 1'($urandom_range(1)));
                if ($urandom_range(3) == 0) push_event(CMD_ACTIVATE, 1'b1);
                push_event(CMD_ACTIVATE, 1'b0);
                k = $urandom_range(1, 80);
                repeat (k) push_event(CMD_TICK, 1'($urandom_range(1)));
            end else begin
                k = $urandom_range(1, 4);
                repeat (k) push_event(cmd_t'($urandom_range(3)), 1'($urandom_range(1)));
            end
        end
    endtask

    // sender pauses at every phase boundary until all results are back
    task automatic run_phase(logic [7:0] acc, logic [7:0] dec, logic [7:0] ceil_v,
                             logic [7:0] pre, int idle, int stall, int n);
        wait_drained();
        write_reg(CFG_ACCEL_STEP, acc);
        write_reg(CFG_DECEL_STEP, dec);
        write_reg(CFG_CEILING, ceil_v);
        write_reg(CFG_PRESET_MIN, pre);
        sender_idle_pct = idle;
        stall_pct       = stall;
        fill_random(n);
    endtask

    initial begin : main_proc
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed, reset register values
        push_event(CMD_TICK, 1'b0);
        push_event(CMD_DIRECTION, 1'b1);
        push_event(CMD_DIRECTION, 1'b0);
        push_event(CMD_PREPARE, 1'b0);
        push_event(CMD_ACTIVATE, 1'b0);
        push_event(CMD_TICK, 1'b1);
        push_event(CMD_ACTIVATE, 1'b1);
        push_event(CMD_TICK, 1'b0);
        push_event(CMD_TICK, 1'b1);
        push_event(CMD_PREPARE, 1'b1);
        push_event(CMD_DIRECTION, 1'b1);
        push_event(CMD_DIRECTION, 1'b0);
        push_event(CMD_ACTIVATE, 1'b0);
        push_event(CMD_TICK, 1'b0);
        push_event(CMD_TICK, 1'b0);
        push_event(CMD_TICK, 1'b1);
        push_event(CMD_DIRECTION, 1'b1);
        push_event(CMD_PREPARE, 1'b0);
        fill_random(180);

        // full-scale steps and preset
        run_phase(8'd255, 8'd255, 8'd255, 8'd255, 51, 0, 230);

        // zero steps, ceiling and preset of one
        run_phase(8'd0, 8'd0, 8'd1, 8'd1, 0, 51, 230);

        // zero ceiling
        run_phase(8'd3, 8'd1, 8'd0, 8'd5, 36, 36, 80);

        // long receiver hold while the sender keeps offering
        wait_drained();
        rx_hold_go <= 1'b1;
        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 36, 36, 230);

        run_phase(8'd16, 8'd1, 8'd200, 8'd40, 0, 0, 230);

        run_phase(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)), 36, 36, 230);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mdrc_pkg.sv
rtl/mdrc_in_stage.sv
rtl/mdrc_core.sv
rtl/mdrc_out_stage.sv
rtl/motor_duty_ramp_controller_top.sv
rtl/mdrc_checker.sv
test/tb_motor_duty_ramp_controller_top.sv
